>>> hdl/csort_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csort_pkg
// Shared constants and types of the counting sort engine.
// ----------------------------------------------------------------------------
package csort_pkg;

    localparam int KEY_W     = 16;
    localparam int DROP_W    = 16;
    localparam int BINS      = 256;
    localparam int BIN_W     = $clog2(BINS);
    localparam int MAX_ITEMS = 64;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    localparam logic [KEY_W-1:0] KEY_FLOOR_RST = 16'hFF80;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INC,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_EMIT,
        ST_EMPTY
    } csort_state_t;

    typedef struct packed {
        logic             we;
        logic [BIN_W-1:0] waddr;
        logic [CNT_W-1:0] wdata;
        logic [BIN_W-1:0] raddr;
    } csort_ram_req_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  sorted_key;
        logic              valid_res;
        logic [DROP_W-1:0] dropped;
        logic              end_of_set;
    } csort_emit_t;

endpackage
`default_nettype wire

>>> hdl/csort_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csort_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module csort_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> hdl/csort_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csort_core
// Histogram sequencer: clear sweep, read-modify-write count, ascending walk.
// ----------------------------------------------------------------------------
module csort_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [csort_pkg::KEY_W-1:0]   key_floor,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [csort_pkg::KEY_W-1:0]   s_key,
    input  wire logic                          s_tlast,
    output csort_pkg::csort_ram_req_t          ram_req,
    input  wire logic [csort_pkg::CNT_W-1:0]   ram_rdata,
    input  wire logic                          out_free,
    output csort_pkg::csort_emit_t             emit
);
    import csort_pkg::*;

    csort_state_t      state_reg, state_next;
    logic [BIN_W-1:0]  bin_reg, bin_next;
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DROP_W-1:0] drop_reg, drop_next;
    logic              last_reg, last_next;

    logic [KEY_W:0]    off;
    logic              s_keep;

    assign off    = {s_key[KEY_W-1], s_key} - {key_floor[KEY_W-1], key_floor};
    assign s_keep = (off[KEY_W:BIN_W] == '0) && (kept_reg < CNT_W'(MAX_ITEMS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            bin_reg   <= '0;
            kept_reg  <= '0;
            cnt_reg   <= '0;
            drop_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bin_reg   <= bin_next;
            kept_reg  <= kept_next;
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        bin_next      = bin_reg;
        kept_next     = kept_reg;
        cnt_next      = cnt_reg;
        drop_next     = drop_reg;
        last_next     = last_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = bin_reg;
        ram_req.wdata = '0;
        ram_req.raddr = bin_reg;
        s_tready      = 1'b0;
        emit          = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_req.we = 1'b1;
                if (bin_reg == BIN_W'(BINS - 1))
                begin
                    bin_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    bin_next = bin_reg + BIN_W'(1);
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    last_next = s_tlast;
                    if (s_keep)
                    begin
                        bin_next      = off[BIN_W-1:0];
                        ram_req.raddr = off[BIN_W-1:0];
                        kept_next     = kept_reg + CNT_W'(1);
                        state_next    = ST_INC;
                    end
                    else
                    begin
                        if (drop_reg != '1)
                        begin
                            drop_next = drop_reg + DROP_W'(1);
                        end
                        if (s_tlast)
                        begin
                            bin_next   = '0;
                            state_next = ST_WALK_RD;
                        end
                    end
                end
            end
            ST_INC:
            begin
                ram_req.we    = 1'b1;
                ram_req.wdata = ram_rdata + CNT_W'(1);
                if (last_reg)
                begin
                    bin_next   = '0;
                    state_next = ST_WALK_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WALK_RD:
            begin
                if (kept_reg == '0)
                begin
                    state_next = ST_EMPTY;
                end
                else
                begin
                    state_next = ST_WALK_CHK;
                end
            end
            ST_WALK_CHK:
            begin
                ram_req.we = 1'b1;
                if (ram_rdata == '0)
                begin
                    bin_next      = bin_reg + BIN_W'(1);
                    ram_req.raddr = bin_reg + BIN_W'(1);
                end
                else
                begin
                    cnt_next   = ram_rdata;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit.valid      = 1'b1;
                    emit.sorted_key = key_floor + KEY_W'(bin_reg);
                    emit.valid_res  = 1'b1;
                    emit.end_of_set = (kept_reg == CNT_W'(1));
                    emit.dropped    = (kept_reg == CNT_W'(1)) ? drop_reg : '0;
                    kept_next       = kept_reg - CNT_W'(1);
                    cnt_next        = cnt_reg - CNT_W'(1);
                    if (kept_reg == CNT_W'(1))
                    begin
                        drop_next  = '0;
                        bin_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else if (cnt_reg == CNT_W'(1))
                    begin
                        bin_next      = bin_reg + BIN_W'(1);
                        ram_req.raddr = bin_reg + BIN_W'(1);
                        state_next    = ST_WALK_CHK;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    emit.valid      = 1'b1;
                    emit.end_of_set = 1'b1;
                    emit.dropped    = drop_reg;
                    drop_next       = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                bin_next   = '0;
            end
        endcase
    end

    a_kept_cap: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= CNT_W'(MAX_ITEMS))
        else $error("kept count above capacity");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> out_free)
        else $error("result emitted into a full output register");

    a_keep_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_keep) |=> (state_reg == ST_INC))
        else $error("kept key did not enter the count update");

    a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.valid && !emit.valid_res) |-> (emit.end_of_set && kept_reg == '0))
        else $error("invalid result outside an empty set");

    a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.valid && emit.end_of_set) |=> (kept_reg == '0 && drop_reg == '0))
        else $error("set counters not cleared after final result");

endmodule
`default_nettype wire

>>> hdl/counting_sort_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// counting_sort_engine
// Sorts one set of signed 16-bit keys through a 256-bin count histogram.
//
//   channel  dir  handshake          payload
//   s_*      in   tvalid/tready      tdata[15:0] key, tlast = last of set
//   m_*      out  tvalid/tready      tdata[15:0] sorted_key, [31:16] dropped,
//                                    tuser = valid_res, tlast = end_of_set
//   cfg_*    in   we                 wdata[15:0] lowest kept key
//
// A kept key gets a histogram read and an increment write-back; a dropped key neither.
// After the last key the walk reads bins upward to the highest kept key and emits every
// kept key, or one key-less result for an empty set; the walk zeroes each bin it reads.
// After reset a sweep over all 256 bins clears the histogram with s_tready low.
// One output register holds a result; m_tready low stalls the walk.
// ----------------------------------------------------------------------------
module counting_sort_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] key
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [15:0] sorted_key, [31:16] dropped
    output logic             m_tuser,   // [0] valid_res
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata  // [15:0] lowest kept key
);
    import csort_pkg::*;

    logic [KEY_W-1:0]  key_floor_reg;
    csort_ram_req_t    ram_req;
    logic [CNT_W-1:0]  ram_rdata;
    csort_emit_t       emit;
    logic              out_free;

    logic              out_valid_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic [DROP_W-1:0] out_drop_reg;
    logic              out_vres_reg;
    logic              out_eos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_floor_reg <= KEY_FLOOR_RST;
        end
        else if (cfg_we)
        begin
            key_floor_reg <= cfg_wdata;
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    csort_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_floor (key_floor_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_key     (s_tdata),
        .s_tlast   (s_tlast),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .out_free  (out_free),
        .emit      (emit)
    );

    csort_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BINS)
    ) u_hist (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_key_reg  <= emit.sorted_key;
            out_drop_reg <= emit.dropped;
            out_vres_reg <= emit.valid_res;
            out_eos_reg  <= emit.end_of_set;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_drop_reg, out_key_reg};
    assign m_tuser  = out_vres_reg;
    assign m_tlast  = out_eos_reg;

endmodule
`default_nettype wire

>>> tb/counting_sort_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_sort_engine_test
// Self-checking bench for the counting sort engine. Keys are streamed in as
// sets; a local histogram model predicts every sorted result, and each
// output request is compared field by field with the oldest prediction.
// Covers window edges, empty sets, capacity overflow, a window moved in the
// middle of a set, backpressure and random traffic.
// ----------------------------------------------------------------------------
module counting_sort_engine_test;

    import csort_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int CFG_SETTLE   = 8;
    localparam int END_WAIT     = 64;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic [15:0] sorted_key;
        logic        valid_res;
        logic [15:0] dropped;
        logic        end_of_set;
    } sort_result_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;

    logic [6:0]   bin_tally [BINS];
    int           kept_total;
    logic [15:0]  drop_total;
    logic [15:0]  window_low;
    sort_result_t sorted_q [$];

    int mismatches    = 0;
    int results_seen  = 0;
    int sets_done     = 0;
    int windows_set   = 0;
    int cycle_count   = 0;
    int rx_hold_cycles = 0;
    bit tx_idle_en    = 1'b1;
    bit rx_idle_en    = 1'b1;

    counting_sort_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, sorted_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Histogram model
    // ------------------------------------------------------------------------
    function automatic void clear_histogram();
        for (int b = 0; b < BINS; b++)
            bin_tally[b] = '0;
        kept_total = 0;
        drop_total = '0;
    endfunction

    task automatic tally_key(input logic [15:0] key, input logic last);
        int           off;
        int           emitted;
        sort_result_t r;
        off = int'($signed(key)) - int'($signed(window_low));
        if (off < 0 || off >= BINS || kept_total >= MAX_ITEMS)
        begin
            if (drop_total != 16'hFFFF)
                drop_total++;
        end
        else
        begin
            bin_tally[off]++;
            kept_total++;
        end
        if (!last)
            return;
        sets_done++;
        emitted = 0;
        if (kept_total == 0)
        begin
            r = '{sorted_key: '0, valid_res: 1'b0, dropped: drop_total, end_of_set: 1'b1};
            sorted_q = {sorted_q, r};
        end
        for (int b = 0; b < BINS; b++)
        begin
            for (int c = 0; c < bin_tally[b]; c++)
            begin
                emitted++;
                r.sorted_key = window_low + 16'(b);
                r.valid_res  = 1'b1;
                r.end_of_set = (emitted == kept_total);
                r.dropped    = r.end_of_set ? drop_total : '0;
                sorted_q = {sorted_q, r};
            end
        end
        clear_histogram();
    endtask

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        sort_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (sorted_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result: expected none, actual key %0d last %0b",
                         $time, $signed(m_tdata[15:0]), m_tlast);
            end
            else
            begin
                want = sorted_q.pop_front();
                if (m_tdata[15:0] !== want.sorted_key)
                begin
                    mismatches++;
                    $display("%0t: sorted_key: expected %0d, actual %0d", $time,
                             $signed(want.sorted_key), $signed(m_tdata[15:0]));
                end
                if (m_tuser !== want.valid_res)
                begin
                    mismatches++;
                    $display("%0t: valid_res: expected %0b, actual %0b", $time,
                             want.valid_res, m_tuser);
                end
                if (m_tdata[31:16] !== want.dropped)
                begin
                    mismatches++;
                    $display("%0t: dropped: expected %0d, actual %0d", $time,
                             want.dropped, m_tdata[31:16]);
                end
                if (m_tlast !== want.end_of_set)
                begin
                    mismatches++;
                    $display("%0t: end_of_set: expected %0b, actual %0b", $time,
                             want.end_of_set, m_tlast);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver ready: random stalls, plus a long hold on request
    // ------------------------------------------------------------------------
    initial
    begin : drive_ready
        int span;
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                span = rx_hold_cycles;
                rx_hold_cycles = 0;
                m_tready <= 1'b0;
                repeat (span) @(posedge clk);
            end
            else if (rx_idle_en && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat (rx_idle_en ? $urandom_range(1, 10) : 1) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------------
    task automatic send_req(input logic [15:0] key, input logic last);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        tally_key(key, last);
    endtask

    task automatic wait_drain(input int settle);
        s_tvalid <= 1'b0;
        while (sorted_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_window(input logic [15:0] low);
        cfg_wdata <= low;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        window_low = low;
        windows_set++;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_window();
        case ($urandom_range(0, 6))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return KEY_FLOOR_RST;
            3:       return 16'h0000;
            4:       return 16'h7F00;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_window();
        send_req(16'hFF80, 1'b0);
        send_req(16'h007F, 1'b0);
        send_req(16'hFF7F, 1'b0);
        send_req(16'h0080, 1'b0);
        send_req(16'h8000, 1'b0);
        send_req(16'h7FFF, 1'b0);
        send_req(16'h0000, 1'b0);
        send_req(16'h007F, 1'b0);
        send_req(16'hFFFF, 1'b0);
        send_req(16'h0005, 1'b1);
        wait_drain(CFG_SETTLE);
    endtask

    task automatic test_empty_sets();
        send_req(16'h7FFF, 1'b1);
        send_req(16'h8000, 1'b0);
        send_req(16'h0100, 1'b0);
        send_req(16'hFF00, 1'b1);
        send_req(16'h0001, 1'b1);
        wait_drain(CFG_SETTLE);
    endtask

    task automatic test_window_edges();
        write_window(16'h8000);
        send_req(16'h8000, 1'b0);
        send_req(16'h80FF, 1'b0);
        send_req(16'h8100, 1'b0);
        send_req(16'h7FFF, 1'b0);
        send_req(16'h8000, 1'b1);
        wait_drain(CFG_SETTLE);
        write_window(16'h7FFF);
        send_req(16'h8000, 1'b0);
        send_req(16'h7FFF, 1'b1);
        wait_drain(CFG_SETTLE);
        write_window(16'h7F00);
        send_req(16'h7FFF, 1'b0);
        send_req(16'h7F00, 1'b1);
        wait_drain(CFG_SETTLE);
    endtask

    task automatic test_window_shift();
        write_window(16'h0000);
        send_req(16'd200, 1'b0);
        send_req(16'd3, 1'b0);
        wait_drain(CFG_SETTLE);
        // keys rebuild from the new window and wrap past +32767
        write_window(16'h7FFF);
        send_req(16'h7FFF, 1'b1);
        wait_drain(CFG_SETTLE);
    endtask

    task automatic test_capacity();
        write_window(KEY_FLOOR_RST);
        for (int i = 0; i < MAX_ITEMS; i++)
            send_req(16'h0011, 1'b0);
        for (int i = 0; i < 6; i++)
            send_req(16'($urandom_range(0, 100)), i == 5);
        wait_drain(CFG_SETTLE);
    endtask

    task automatic test_backpressure();
        rx_hold_cycles = LONG_HOLD;
        for (int i = 0; i < 30; i++)
            send_req(window_low + 16'($urandom_range(0, BINS - 1)), i == 29);
        // keep offering the next set while the output is held
        for (int i = 0; i < 20; i++)
            send_req(window_low + 16'($urandom_range(0, BINS - 1)), i == 19);
        wait_drain(CFG_SETTLE);
        for (int i = 0; i < 8; i++)
            send_req(window_low + 16'($urandom_range(0, BINS - 1)), i == 7);
        wait_drain(CFG_SETTLE);
    endtask

    task automatic test_random_sets(input int quota);
        int          sent;
        int          len;
        logic [15:0] key;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                wait_drain(CFG_SETTLE);
                write_window(pick_window());
            end
            case ($urandom_range(0, 19))
                0:       len = $urandom_range(60, 72);
                1, 2:    len = $urandom_range(17, 40);
                default: len = $urandom_range(1, 16);
            endcase
            if (len > quota - sent)
                len = quota - sent;
            for (int i = 0; i < len; i++)
            begin
                if (len > 4 && i == len / 2 && $urandom_range(0, 9) == 0)
                begin
                    wait_drain(CFG_SETTLE);
                    write_window(pick_window());
                end
                if ($urandom_range(0, 9) < 7)
                    key = window_low + 16'($urandom_range(0, BINS - 1));
                else
                    key = 16'($urandom_range(0, 65535));
                send_req(key, i == len - 1);
            end
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clear_histogram();
        window_low = KEY_FLOOR_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_empty_sets();
        test_window_edges();
        test_window_shift();
        test_capacity();
        write_window(KEY_FLOOR_RST);
        test_backpressure();
        test_random_sets(80);

        wait_drain(CFG_SETTLE);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_sets(25);

        wait_drain(END_WAIT);
        $display("Sorted %0d sets, checked %0d results, %0d window writes.",
                 sets_done, results_seen, windows_set);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
